FILE: src/cts_pkg.sv
`default_nettype none

package cts_pkg;

    // series length and table reach
    localparam int MAX_TERMS = 16;
    localparam int TBL_DEPTH = 32;
    localparam int TIX_W     = $clog2(TBL_DEPTH);

    // port widths
    localparam int X_W    = 31;
    localparam int TOL_W  = 31;
    localparam int COS_W  = 32;
    localparam int TU_W   = 5;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // term counter, wide enough for the count and for the output clamp
    localparam int CNT_RAW_W = $clog2(MAX_TERMS + 1);
    localparam int CNT_W     = (CNT_RAW_W > TU_W) ? CNT_RAW_W : TU_W;
    localparam int TU_MAX    = (2 ** TU_W) - 1;
    localparam int TU_LIMIT  = (MAX_TERMS > TU_MAX) ? TU_MAX : MAX_TERMS;

    // register map
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = 31'd10737;

    // datapath widths
    localparam int Q_FRAC    = 30;
    localparam int X2_SHIFT  = 26;
    localparam int SQ_W      = 62;
    localparam int MAG_W     = 34;
    localparam int X2_W      = 35;
    localparam int ML_W      = 17;
    localparam int XL_W      = 18;
    localparam int PP_W      = ML_W + XL_W;
    localparam int ACC_W     = 70;
    localparam int P_W       = ACC_W - Q_FRAC;
    localparam int SUM_W     = 38;
    localparam int DIV_W     = 12;
    localparam int RCP_W     = 32;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DIG_W     = 8;
    localparam int NDIG      = P_W / DIG_W;
    localparam int DIG_IDX_W = $clog2(NDIG);
    localparam int T_W       = DIV_W + DIG_W;

    localparam logic [MAG_W-1:0] ONE_Q30 = MAG_W'(64'd1 << Q_FRAC);
    localparam logic [SQ_W-1:0]  SQ_HALF = SQ_W'(64'd1 << (X2_SHIFT - 1));

    localparam logic signed [SUM_W-1:0] SUM_POS_ONE = SUM_W'(64'd1 << Q_FRAC);
    localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_POS_ONE;
    localparam logic signed [COS_W-1:0] COS_POS_ONE = COS_W'(64'd1 << Q_FRAC);
    localparam logic signed [COS_W-1:0] COS_NEG_ONE = -COS_POS_ONE;

    localparam logic [1:0] PP_LAST = 2'd3;

    // ceil(2^32 / d) for d = (2n-1)*2n, n = 1 .. TBL_DEPTH
    localparam logic [63:0] RCP_NUM = 64'd4294967296;
    localparam logic [63:0] RCP_WIDE [TBL_DEPTH] = '{
        (RCP_NUM + 64'd1)    / 64'd2,    (RCP_NUM + 64'd11)   / 64'd12,
        (RCP_NUM + 64'd29)   / 64'd30,   (RCP_NUM + 64'd55)   / 64'd56,
        (RCP_NUM + 64'd89)   / 64'd90,   (RCP_NUM + 64'd131)  / 64'd132,
        (RCP_NUM + 64'd181)  / 64'd182,  (RCP_NUM + 64'd239)  / 64'd240,
        (RCP_NUM + 64'd305)  / 64'd306,  (RCP_NUM + 64'd379)  / 64'd380,
        (RCP_NUM + 64'd461)  / 64'd462,  (RCP_NUM + 64'd551)  / 64'd552,
        (RCP_NUM + 64'd649)  / 64'd650,  (RCP_NUM + 64'd755)  / 64'd756,
        (RCP_NUM + 64'd869)  / 64'd870,  (RCP_NUM + 64'd991)  / 64'd992,
        (RCP_NUM + 64'd1121) / 64'd1122, (RCP_NUM + 64'd1259) / 64'd1260,
        (RCP_NUM + 64'd1405) / 64'd1406, (RCP_NUM + 64'd1559) / 64'd1560,
        (RCP_NUM + 64'd1721) / 64'd1722, (RCP_NUM + 64'd1891) / 64'd1892,
        (RCP_NUM + 64'd2069) / 64'd2070, (RCP_NUM + 64'd2255) / 64'd2256,
        (RCP_NUM + 64'd2449) / 64'd2450, (RCP_NUM + 64'd2651) / 64'd2652,
        (RCP_NUM + 64'd2861) / 64'd2862, (RCP_NUM + 64'd3079) / 64'd3080,
        (RCP_NUM + 64'd3305) / 64'd3306, (RCP_NUM + 64'd3539) / 64'd3540,
        (RCP_NUM + 64'd3781) / 64'd3782, (RCP_NUM + 64'd4031) / 64'd4032
    };

    function automatic logic [RCP_W-1:0] cts_recip(input logic [TIX_W-1:0] idx);
        return RCP_W'(RCP_WIDE[idx]);
    endfunction

    // (2n-1)*2n with n = idx + 1
    function automatic logic [DIV_W-1:0] cts_divisor(input logic [TIX_W-1:0] idx);
        logic [TIX_W+1:0] odd_f;
        logic [TIX_W+1:0] even_f;
        logic [2*TIX_W+3:0] prod;
        odd_f  = {1'b0, idx, 1'b1};
        even_f = {1'b0, idx, 1'b0} + (TIX_W+2)'(2);
        prod   = (2*TIX_W+4)'(odd_f) * (2*TIX_W+4)'(even_f);
        return DIV_W'(prod);
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQW,
        ST_CHK,
        ST_PP,
        ST_PPA,
        ST_DQ,
        ST_DQW,
        ST_DR,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: src/cosine_taylor_series_unit.sv
`default_nettype none

// cosine by its maclaurin series, one angle per transfer. i_x_angle is a signed
// q3.28 angle; the unit sums 1 - x^2/2! + x^4/4! - ... with each term derived
// from the previous one as term * x^2 / ((2n-1)*2n), and stops once a term is
// not above the tolerance register (q1.30, address 0, reset about 1e-5) or
// MAX_TERMS terms have been added. o_cos_value is the q2.30 sum clamped to
// plus or minus one, o_terms_used the terms added, o_hit_limit set when the
// term limit ended the loop. everything runs on one 32x32 multiplier with a
// registered product under a small sequencer: squaring the angle, four partial
// products for each term times x^2, and a byte-at-a-time divide by the term's
// constant through a reciprocal table (two multiplies per byte, five bytes).
// o_ready is high only while the unit is idle, and the finished result sits
// in an output register, so a new angle can be taken while the last result
// still waits.
module cosine_taylor_series_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // angle channel
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  signed [cts_pkg::X_W-1:0]      i_x_angle,
    // result channel
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic signed [cts_pkg::COS_W-1:0]    o_cos_value,
    output logic        [cts_pkg::TU_W-1:0]     o_terms_used,
    output logic                                o_hit_limit,
    // register port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire         [cts_pkg::ADDR_W-1:0]   paddr,
    input  wire         [cts_pkg::DATA_W-1:0]   pwdata,
    output logic        [cts_pkg::DATA_W-1:0]   prdata,
    output logic                                pready
);

    // control state
    cts_pkg::t_state                    r_state, n_state;
    logic [cts_pkg::TOL_W-1:0]          r_tol, n_tol;
    logic                               r_ovalid, n_ovalid;

    // working registers
    logic [cts_pkg::X_W-1:0]            r_ax, n_ax;
    logic [cts_pkg::PROD_W-1:0]         r_prod;
    logic [cts_pkg::X2_W-1:0]           r_x2, n_x2;
    logic [cts_pkg::MAG_W-1:0]          r_mag, n_mag;
    logic                               r_neg, n_neg;
    logic signed [cts_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [cts_pkg::CNT_W-1:0]          r_count, n_count;
    logic [cts_pkg::TIX_W-1:0]          r_tix, n_tix;
    logic [cts_pkg::DIV_W-1:0]          r_div, n_div;
    logic [1:0]                         r_pp, n_pp;
    logic [cts_pkg::ACC_W-1:0]          r_acc, n_acc;
    logic [cts_pkg::P_W-1:0]            r_quo, n_quo;
    logic [cts_pkg::DIV_W-1:0]          r_rem, n_rem;
    logic [cts_pkg::DIG_IDX_W-1:0]      r_dig, n_dig;
    logic [cts_pkg::DIG_W-1:0]          r_qdig, n_qdig;

    // output registers
    logic signed [cts_pkg::COS_W-1:0]   r_cos, n_cos;
    logic [cts_pkg::TU_W-1:0]           r_terms, n_terms;
    logic                               r_hit, n_hit;

    // shared multiplier
    logic [cts_pkg::MUL_W-1:0]          mul_a, mul_b;
    logic [cts_pkg::PROD_W-1:0]         n_prod;

    // helpers
    logic                               in_xfer;
    logic                               out_free;
    logic                               above_tol;
    logic                               term_go;
    logic                               last_dig;
    logic                               cfg_wr;
    logic [cts_pkg::X_W-1:0]            raw_neg;
    logic [cts_pkg::SQ_W-1:0]           sq_rnd;
    logic [cts_pkg::ACC_W-1:0]          pp_ext, pp_sh;
    logic [cts_pkg::T_W-1:0]            div_t, div_diff;
    logic [cts_pkg::P_W-1:0]            quo_next;
    logic signed [cts_pkg::SUM_W-1:0]   mag_s;

    assign o_ready   = (r_state == cts_pkg::ST_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign out_free  = !r_ovalid || i_ready;
    assign above_tol = r_mag > cts_pkg::MAG_W'(r_tol);
    assign term_go   = above_tol && (r_count < cts_pkg::CNT_W'(cts_pkg::MAX_TERMS));
    assign last_dig  = (r_dig == cts_pkg::DIG_IDX_W'(cts_pkg::NDIG - 1));

    // register port: one register, pready held high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == cts_pkg::REG_TOLERANCE) ?
                    cts_pkg::DATA_W'(r_tol) : '0;

    assign o_valid      = r_ovalid;
    assign o_cos_value  = r_cos;
    assign o_terms_used = r_terms;
    assign o_hit_limit  = r_hit;

    // magnitude of the angle in 31 bits, -2^30 maps to 2^30
    assign raw_neg = ~i_x_angle + cts_pkg::X_W'(1);

    // x^2 in q.30, rounded half up
    assign sq_rnd = r_prod[cts_pkg::SQ_W-1:0] + cts_pkg::SQ_HALF;

    // current dividend digit joins the running remainder
    assign div_t    = {r_rem, r_quo[cts_pkg::P_W-1 -: cts_pkg::DIG_W]};
    assign div_diff = div_t - r_prod[cts_pkg::T_W-1:0];
    assign quo_next = {r_quo[cts_pkg::P_W-cts_pkg::DIG_W-1:0], r_qdig};

    assign mag_s  = $signed({{(cts_pkg::SUM_W-cts_pkg::MAG_W){1'b0}}, r_mag});
    assign pp_ext = cts_pkg::ACC_W'(r_prod[cts_pkg::PP_W-1:0]);

    // partial product alignment: lo*lo, lo*xhi, mhi*lo, mhi*xhi
    always_comb begin
        unique case (r_pp)
            2'd0:    pp_sh = pp_ext;
            2'd1:    pp_sh = pp_ext << cts_pkg::XL_W;
            2'd2:    pp_sh = pp_ext << cts_pkg::ML_W;
            default: pp_sh = pp_ext << cts_pkg::PP_W;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            cts_pkg::ST_SQ: begin
                mul_a = cts_pkg::MUL_W'(r_ax);
                mul_b = cts_pkg::MUL_W'(r_ax);
            end
            cts_pkg::ST_PP: begin
                unique case (r_pp)
                    2'd0: begin
                        mul_a = cts_pkg::MUL_W'(r_mag[cts_pkg::ML_W-1:0]);
                        mul_b = cts_pkg::MUL_W'(r_x2[cts_pkg::XL_W-1:0]);
                    end
                    2'd1: begin
                        mul_a = cts_pkg::MUL_W'(r_mag[cts_pkg::ML_W-1:0]);
                        mul_b = cts_pkg::MUL_W'(r_x2[cts_pkg::X2_W-1:cts_pkg::XL_W]);
                    end
                    2'd2: begin
                        mul_a = cts_pkg::MUL_W'(r_mag[cts_pkg::MAG_W-1:cts_pkg::ML_W]);
                        mul_b = cts_pkg::MUL_W'(r_x2[cts_pkg::XL_W-1:0]);
                    end
                    default: begin
                        mul_a = cts_pkg::MUL_W'(r_mag[cts_pkg::MAG_W-1:cts_pkg::ML_W]);
                        mul_b = cts_pkg::MUL_W'(r_x2[cts_pkg::X2_W-1:cts_pkg::XL_W]);
                    end
                endcase
            end
            cts_pkg::ST_DQ: begin
                // digit quotient estimate, exact for 20-bit numerators
                mul_a = cts_pkg::MUL_W'(div_t);
                mul_b = cts_pkg::cts_recip(r_tix);
            end
            cts_pkg::ST_DQW: begin
                // quotient digit back times the divisor
                mul_a = cts_pkg::MUL_W'(r_prod[cts_pkg::RCP_W +: cts_pkg::DIG_W]);
                mul_b = cts_pkg::MUL_W'(r_div);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = cts_pkg::PROD_W'(mul_a) * cts_pkg::PROD_W'(mul_b);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cts_pkg::ST_IDLE: if (i_valid) begin
                n_state = cts_pkg::ST_SQ;
            end
            cts_pkg::ST_SQ:  n_state = cts_pkg::ST_SQW;
            cts_pkg::ST_SQW: n_state = cts_pkg::ST_CHK;
            cts_pkg::ST_CHK: begin
                n_state = term_go ? cts_pkg::ST_PP : cts_pkg::ST_FIN;
            end
            cts_pkg::ST_PP:  n_state = cts_pkg::ST_PPA;
            cts_pkg::ST_PPA: begin
                n_state = (r_pp == cts_pkg::PP_LAST) ? cts_pkg::ST_DQ : cts_pkg::ST_PP;
            end
            cts_pkg::ST_DQ:  n_state = cts_pkg::ST_DQW;
            cts_pkg::ST_DQW: n_state = cts_pkg::ST_DR;
            cts_pkg::ST_DR: begin
                n_state = last_dig ? cts_pkg::ST_CHK : cts_pkg::ST_DQ;
            end
            cts_pkg::ST_FIN: if (out_free) begin
                n_state = cts_pkg::ST_IDLE;
            end
            default: n_state = cts_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_tol    = r_tol;
        n_ovalid = r_ovalid;
        n_ax     = r_ax;
        n_x2     = r_x2;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_sum    = r_sum;
        n_count  = r_count;
        n_tix    = r_tix;
        n_div    = r_div;
        n_pp     = r_pp;
        n_acc    = r_acc;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dig    = r_dig;
        n_qdig   = r_qdig;
        n_cos    = r_cos;
        n_terms  = r_terms;
        n_hit    = r_hit;

        if (cfg_wr && (paddr[2] == cts_pkg::REG_TOLERANCE)) begin
            n_tol = pwdata[cts_pkg::TOL_W-1:0];
        end

        // result taken by the sink
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            cts_pkg::ST_IDLE: if (in_xfer) begin
                n_ax = i_x_angle[cts_pkg::X_W-1] ? raw_neg : i_x_angle;
            end
            cts_pkg::ST_SQW: begin
                n_x2    = sq_rnd[cts_pkg::X2_SHIFT +: cts_pkg::X2_W];
                n_mag   = cts_pkg::ONE_Q30;
                n_neg   = 1'b0;
                n_sum   = '0;
                n_count = '0;
            end
            cts_pkg::ST_CHK: if (term_go) begin
                // add this term, then derive the next one
                n_sum   = r_neg ? (r_sum - mag_s) : (r_sum + mag_s);
                n_count = r_count + cts_pkg::CNT_W'(1);
                n_tix   = cts_pkg::TIX_W'(r_count);
                n_div   = cts_pkg::cts_divisor(cts_pkg::TIX_W'(r_count));
                n_pp    = '0;
                n_acc   = '0;
            end
            cts_pkg::ST_PPA: begin
                n_acc = r_acc + pp_sh;
                if (r_pp == cts_pkg::PP_LAST) begin
                    // floor(m * x^2 / 2^30) becomes the dividend
                    n_quo = n_acc[cts_pkg::ACC_W-1:cts_pkg::Q_FRAC];
                    n_rem = '0;
                    n_dig = '0;
                end else begin
                    n_pp = r_pp + 2'd1;
                end
            end
            cts_pkg::ST_DQW: begin
                n_qdig = r_prod[cts_pkg::RCP_W +: cts_pkg::DIG_W];
            end
            cts_pkg::ST_DR: begin
                n_rem = div_diff[cts_pkg::DIV_W-1:0];
                n_quo = quo_next;
                n_dig = r_dig + cts_pkg::DIG_IDX_W'(1);
                if (last_dig) begin
                    n_mag = quo_next[cts_pkg::MAG_W-1:0];
                    n_neg = !r_neg;
                end
            end
            cts_pkg::ST_FIN: if (out_free) begin
                n_ovalid = 1'b1;
                n_hit    = above_tol;
                if (r_sum > cts_pkg::SUM_POS_ONE) begin
                    n_cos = cts_pkg::COS_POS_ONE;
                end else if (r_sum < cts_pkg::SUM_NEG_ONE) begin
                    n_cos = cts_pkg::COS_NEG_ONE;
                end else begin
                    n_cos = cts_pkg::COS_W'(r_sum);
                end
                if (r_count > cts_pkg::CNT_W'(cts_pkg::TU_LIMIT)) begin
                    n_terms = cts_pkg::TU_W'(cts_pkg::TU_LIMIT);
                end else begin
                    n_terms = cts_pkg::TU_W'(r_count);
                end
            end
            default: begin
                n_ax = r_ax;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cts_pkg::ST_IDLE;
            r_tol    <= cts_pkg::TOL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tol    <= n_tol;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_ax    <= n_ax;
        r_x2    <= n_x2;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_sum   <= n_sum;
        r_count <= n_count;
        r_tix   <= n_tix;
        r_div   <= n_div;
        r_pp    <= n_pp;
        r_acc   <= n_acc;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dig   <= n_dig;
        r_qdig  <= n_qdig;
        r_cos   <= n_cos;
        r_terms <= n_terms;
        r_hit   <= n_hit;
    end

endmodule

`default_nettype wire

FILE: src/cts_checker.sv
`default_nettype none

module cts_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_ready,
    input wire                              o_valid,
    input wire                              i_ready,
    input wire signed [cts_pkg::COS_W-1:0]  o_cos_value,
    input wire        [cts_pkg::TU_W-1:0]   o_terms_used,
    input wire                              o_hit_limit
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_cos_value)
            && $stable(o_terms_used) && $stable(o_hit_limit)))
        else $error("result changed while stalled");

    // cosine stays within plus or minus one
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_cos_value <= cts_pkg::COS_POS_ONE)
            && (o_cos_value >= cts_pkg::COS_NEG_ONE)))
        else $error("cosine out of range");

    // the limit flag only with a full term count
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_limit) |->
            (o_terms_used == cts_pkg::TU_W'(cts_pkg::TU_LIMIT)))
        else $error("limit flag without full term count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_terms_used <= cts_pkg::TU_W'(cts_pkg::TU_LIMIT)))
        else $error("term count above limit");

    // one angle at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after a transfer");

endmodule

bind cosine_taylor_series_unit cts_checker u_cts_checker (.*);

`default_nettype wire

FILE: test/cosine_taylor_series_unit_tb.sv
`timescale 1ns / 100ps

// result record of one angle: q2.30 cosine, terms added, term-limit flag
typedef struct packed {
    logic signed [cts_pkg::COS_W-1:0] cos_value;
    logic        [cts_pkg::TU_W-1:0]  terms_used;
    logic                             hit_limit;
} t_cos_result;

class cos_scoreboard;
    logic [cts_pkg::TOL_W-1:0] tol;
    t_cos_result               expected_cos[$];
    int                        errors;

    function new();
        tol    = cts_pkg::TOL_RESET;
        errors = 0;
    endfunction

    // series sum of one angle at the current tolerance
    function t_cos_result series_cos(logic signed [cts_pkg::X_W-1:0] x);
        bit [63:0]   raw;
        bit [63:0]   ax;
        bit [63:0]   x2;
        bit [63:0]   mag;
        bit [63:0]   tol_w;
        bit [63:0]   part_hi;
        bit [63:0]   part_lo;
        longint      acc;
        int unsigned cnt;
        int unsigned n;
        bit          neg;
        t_cos_result r;
        raw   = {33'd0, x};
        ax    = x[cts_pkg::X_W-1] ? ((64'h8000_0000 - raw) & 64'h7FFF_FFFF) : raw;
        x2    = (ax * ax + (64'd1 << 25)) >> 26;
        mag   = 64'd1 << 30;
        tol_w = {33'd0, tol};
        acc   = 0;
        cnt   = 0;
        n     = 1;
        neg   = 1'b0;
        while (mag > tol_w && cnt < cts_pkg::MAX_TERMS) begin
            if (neg) begin
                acc = acc - longint'(mag);
            end else begin
                acc = acc + longint'(mag);
            end
            cnt++;
            // term * x^2 in two halves so nothing overflows, then the factorial step
            part_hi = mag * (x2 >> 15);
            part_lo = mag * (x2 & 64'h7FFF);
            mag     = ((part_hi + (part_lo >> 15)) >> 15) / ((2 * n - 1) * (2 * n));
            neg     = !neg;
            n++;
        end
        if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
        if (acc < -(longint'(1) <<< 30)) acc = -(longint'(1) <<< 30);
        r.cos_value  = acc[31:0];
        r.terms_used = (cnt > 31) ? 5'd31 : cnt[4:0];
        r.hit_limit  = (mag > tol_w);
        return r;
    endfunction

    function void note_angle(logic signed [cts_pkg::X_W-1:0] x);
        expected_cos.push_back(series_cos(x));
    endfunction

    function void check_result(t_cos_result got);
        t_cos_result want;
        if (expected_cos.size() == 0) begin
            $display("%0t: unexpected result cos %0d terms %0d hit %0b", $time,
                     got.cos_value, got.terms_used, got.hit_limit);
            errors++;
            return;
        end
        want = expected_cos.pop_front();
        if (got.cos_value !== want.cos_value) begin
            $display("%0t: cos_value expected %0d actual %0d", $time,
                     want.cos_value, got.cos_value);
            errors++;
        end
        if (got.terms_used !== want.terms_used) begin
            $display("%0t: terms_used expected %0d actual %0d", $time,
                     want.terms_used, got.terms_used);
            errors++;
        end
        if (got.hit_limit !== want.hit_limit) begin
            $display("%0t: hit_limit expected %0b actual %0b", $time,
                     want.hit_limit, got.hit_limit);
            errors++;
        end
    endfunction

    function int pending();
        return expected_cos.size();
    endfunction
endclass

module cosine_taylor_series_unit_tb;

    // angle limit, pi in q3.28
    localparam int X_LIM = 843314857;
    // register byte addresses and the index that holds the tolerance
    localparam logic [cts_pkg::ADDR_W-1:0] TOL_ADDR   = 3'd0;
    localparam logic [cts_pkg::ADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam logic                       TOL_INDEX  = 1'b0;
    // worst-case latency of one item (sixteen terms) plus margin
    localparam int DRAIN_CYCLES = 420;
    // long receiver hold-off, far beyond one item so the unit backs up
    localparam int LONG_HOLD = 3000;
    localparam int RUN_LIMIT_NS = 25_000_000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic signed [cts_pkg::X_W-1:0]      i_x_angle;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [cts_pkg::COS_W-1:0]    o_cos_value;
    logic        [cts_pkg::TU_W-1:0]     o_terms_used;
    logic                                o_hit_limit;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic        [cts_pkg::ADDR_W-1:0]   paddr;
    logic        [cts_pkg::DATA_W-1:0]   pwdata;
    logic        [cts_pkg::DATA_W-1:0]   prdata;
    logic                                pready;

    cos_scoreboard sb;
    int            reg_errors;
    // sender-side flags read by the receiver process
    bit            no_idle;
    int            hold_requests;

    cosine_taylor_series_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_x_angle    (i_x_angle),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cos_value  (o_cos_value),
        .o_terms_used (o_terms_used),
        .o_hit_limit  (o_hit_limit),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("cosine_taylor_series_unit_tb failed");
        $finish;
    end

    // result side: sample every accepted transfer at the rising edge
    always @(posedge i_clk) begin
        t_cos_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.cos_value  = o_cos_value;
            got.terms_used = o_terms_used;
            got.hit_limit  = o_hit_limit;
            sb.check_result(got);
        end
    end

    // receiver stalls: short random bursts, quiet windows, and on request one long hold-off
    initial begin
        int stall_left;
        int holds_served;
        int window;
        bit rx_quiet;
        stall_left   = 0;
        holds_served = 0;
        window       = 0;
        rx_quiet     = 1'b0;
        i_ready      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                window   = 256;
                rx_quiet = ($urandom_range(0, 2) == 0);
            end
            window--;
            if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (hold_requests != holds_served) begin
                holds_served++;
                i_ready    = 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (!no_idle && !rx_quiet && $urandom_range(0, 3) == 0) begin
                i_ready    = 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // one angle transfer, preceded by gap idle cycles; valid stays high afterwards
    task automatic send_angle(input logic signed [cts_pkg::X_W-1:0] x, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_x_angle = x;
        do @(posedge i_clk); while (!o_ready);
        sb.note_angle(x);
    endtask

    task automatic stop_angles();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // drop valid and let every expected result come back, then let the unit go quiet
    task automatic drain_results();
        stop_angles();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [cts_pkg::ADDR_W-1:0] addr,
                             input logic [cts_pkg::DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        // only index zero holds a register; everything else is dropped
        if (addr[cts_pkg::ADDR_W-1:2] == TOL_INDEX) sb.tol = data[cts_pkg::TOL_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic tolerance_readback();
        logic [cts_pkg::DATA_W-1:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = TOL_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got[cts_pkg::TOL_W-1:0] !== sb.tol) begin
            $display("%0t: tolerance readback expected %0d actual %0d", $time,
                     sb.tol, got[cts_pkg::TOL_W-1:0]);
            reg_errors++;
        end
    endtask

    // mostly in-range angles, with small ones, raw 31-bit ones and near-limit ones
    function automatic logic signed [cts_pkg::X_W-1:0] pick_angle();
        int unsigned sel;
        logic signed [31:0] v;
        sel = $urandom_range(0, 9);
        if (sel <= 6) begin
            v = int'($urandom_range(0, 2 * X_LIM)) - X_LIM;
        end else if (sel == 7) begin
            v = int'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 1) v = -v;
        end else if (sel == 8) begin
            v = $urandom();
        end else begin
            case ($urandom_range(0, 3))
                0: v = X_LIM - int'($urandom_range(0, 15));
                1: v = -(X_LIM - int'($urandom_range(0, 15)));
                2: v = 32'sh3FFF_FFFF;
                default: v = -32'sh4000_0000;
            endcase
        end
        return v[cts_pkg::X_W-1:0];
    endfunction

    task automatic random_angles(input int count, input bit tx_idle);
        int gap;
        bit tx_quiet;
        tx_quiet = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
            gap = 0;
            if (tx_idle && !no_idle && !tx_quiet && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 10);
            send_angle(pick_angle(), gap);
        end
    endtask

    task automatic set_tolerance(input logic [cts_pkg::DATA_W-1:0] value);
        reg_write(TOL_ADDR, value);
        tolerance_readback();
    endtask

    initial begin
        logic signed [cts_pkg::X_W-1:0] corner_angles[$];
        sb            = new();
        reg_errors    = 0;
        no_idle       = 1'b0;
        hold_requests = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_x_angle     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed angles at the reset tolerance: zero, unit steps, pi, pi/2,
        // the 31-bit extremes and angles beyond pi
        corner_angles = '{31'sd0, 31'sd1, -31'sd1, 31'sd843314857, -31'sd843314857,
                          31'sd421657428, -31'sd421657428, 31'sd268435456,
                          -31'sd268435456, 31'sd536870912, -31'sd536870912,
                          31'sh3FFF_FFFF, -31'sh4000_0000, 31'sd1000000000,
                          -31'sd1000000000, 31'sh2AAA_AAAA, 31'sh5555_5555,
                          31'sd65536, -31'sd65536};
        tolerance_readback();
        foreach (corner_angles[k]) send_angle(corner_angles[k], $urandom_range(0, 2));
        random_angles(180, 1'b1);
        drain_results();

        // tolerance zero: terms run until they vanish or the limit stops them
        set_tolerance(32'd0);
        send_angle(31'sd0, 0);
        send_angle(31'sh3FFF_FFFF, 0);
        send_angle(-31'sh4000_0000, 0);
        random_angles(140, 1'b1);
        drain_results();

        // smallest nonzero tolerance
        set_tolerance(32'd1);
        random_angles(100, 1'b1);
        drain_results();

        // tolerance of one: no term is ever added
        set_tolerance(32'd1073741824);
        random_angles(40, 1'b1);
        drain_results();

        // top bit of the write data is outside the register
        set_tolerance(32'hFFFF_FFFF);
        random_angles(30, 1'b1);
        drain_results();

        // just under one: the first term always goes in, later ones only while they stay above one
        set_tolerance(32'd1073741823);
        random_angles(30, 1'b1);
        drain_results();

        // a write to the unused address leaves the tolerance alone
        reg_write(SPARE_ADDR, 32'd0);
        tolerance_readback();
        random_angles(30, 1'b1);
        drain_results();

        set_tolerance($urandom_range(1, 1 << 20));
        random_angles(150, 1'b1);
        drain_results();

        set_tolerance($urandom());
        random_angles(80, 1'b1);
        drain_results();

        // back to the reset value; receiver holds off while the sender keeps going
        set_tolerance(32'(cts_pkg::TOL_RESET));
        random_angles(20, 1'b1);
        @(negedge i_clk);
        hold_requests++;
        random_angles(80, 1'b1);
        // sender pauses until the unit has handed back everything
        stop_angles();
        while (sb.pending() != 0) @(posedge i_clk);
        random_angles(60, 1'b1);
        // closing stretch at full rate on both sides
        no_idle = 1'b1;
        random_angles(150, 1'b0);
        stop_angles();

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
            $display("cosine_taylor_series_unit_tb passed");
        end else begin
            $display("cosine_taylor_series_unit_tb failed");
        end
        $finish;
    end

endmodule
